@@ design/assert_macros.svh @@
// Assertion macros used by pczb_ctrl.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the asynchronous reset is asserted.
`define CHK_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("check failed");

// Clocked check that also holds through reset.
`define CHK_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("check failed");

`endif

@@ design/pczb_pkg.sv @@
// Types, codes and the depth glyph function of the point cloud z-buffer renderer.
// No dependencies.
package pczb_pkg;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_PLOT  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [2:0] CFG_COS  = 3'd0;
	localparam logic [2:0] CFG_SIN  = 3'd1;
	localparam logic [2:0] CFG_OFF  = 3'd2;
	localparam logic [2:0] CFG_COLS = 3'd3;
	localparam logic [2:0] CFG_ROWS = 3'd4;

	localparam logic [2:0] MUL_XC   = 3'd0;
	localparam logic [2:0] MUL_ZS   = 3'd1;
	localparam logic [2:0] MUL_ZC   = 3'd2;
	localparam logic [2:0] MUL_XS   = 3'd3;
	localparam logic [2:0] MUL_CNUM = 3'd4;
	localparam logic [2:0] MUL_RNUM = 3'd5;

	localparam logic [1:0] ACC_RX_LD  = 2'd0;
	localparam logic [1:0] ACC_RX_SUB = 2'd1;
	localparam logic [1:0] ACC_RZ_LD  = 2'd2;
	localparam logic [1:0] ACC_RZ_ADD = 2'd3;

	localparam int TZW = 28;   // translated depth
	localparam int AW  = 29;   // multiplier operand A
	localparam int BW  = 18;   // multiplier operand B
	localparam int PW  = 47;   // product
	localparam int NW  = 40;   // divider numerator magnitude
	localparam int DW  = 29;   // divider denominator
	localparam int NEAR_LIMIT = 65;
	localparam logic [7:0] SPACE = 8'h20;

	localparam logic [7:0] RAMP [0:8] = '{8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h6F,
		8'h78, 8'h25, 8'h23, 8'h40};

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [23:0] vertex_x;
		logic signed [23:0] vertex_y;
		logic signed [23:0] vertex_z;
		logic [6:0]         read_col;
		logic [5:0]         read_row;
	} item_t;

	typedef struct packed {
		logic [7:0] glyph;
		logic       plotted;
		logic [6:0] screen_col;
		logic [5:0] screen_row;
	} result_t;

	typedef enum logic [1:0] {EM_NONE, EM_SPACE, EM_PLOT, EM_READ} emit_t;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_CLR, ST_EMPTY, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4,
		ST_TZ, ST_MC, ST_DC, ST_DCI, ST_DR, ST_DRI, ST_CHK, ST_UPD, ST_RD, ST_RDO
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [2:0] mul_sel;
		logic       acc_en;
		logic [1:0] acc_sel;
		logic       tz_en;
		logic       div_load;
		logic       div_row;
		logic       div_step;
		logic       sweep;
		logic       mem_rd;
		logic       rd_pix;
		emit_t      emit;
	} ctl_t;

	typedef struct packed {
		logic drop_early;
		logic div_last;
		logic sweep_last;
	} status_t;

	function automatic logic [7:0] glyph_of(input logic [23:0] d);
		logic [3:0]  idx;
		logic [17:0] diff;
		idx = 4'd0;
		diff = 18'(24'd262144 - d);
		if (d <= 24'd98304) begin
			idx = 4'd8;
		end else if (d < 24'd262144) begin
			for (int k = 1; k < 8; k++) begin
				if (diff >= 18'(k * 20480)) idx = 4'(k);
			end
		end
		return RAMP[idx];
	endfunction

endpackage

@@ design/pczb_ctrl.sv @@
// Sequencer of the renderer: steps the datapath through each command.
// Depends on pczb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pczb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        cmd,
	input  pczb_pkg::status_t st,
	output pczb_pkg::ctl_t    ctl,
	output logic              busy
);

	pczb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pczb_pkg::ST_INIT;
		else state_q <= state_d;
	end

	assign busy = (state_q != pczb_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.emit = pczb_pkg::EM_NONE;
		unique case (state_q)
			pczb_pkg::ST_INIT: begin
				ctl.sweep = 1'b1;
				if (st.sweep_last) state_d = pczb_pkg::ST_IDLE;
			end
			pczb_pkg::ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					unique case (cmd)
						pczb_pkg::CMD_CLEAR: state_d = pczb_pkg::ST_CLR;
						pczb_pkg::CMD_PLOT:  state_d = pczb_pkg::ST_M0;
						pczb_pkg::CMD_READ:  state_d = pczb_pkg::ST_RD;
						default:             state_d = pczb_pkg::ST_EMPTY;
					endcase
				end
			end
			pczb_pkg::ST_CLR: begin
				ctl.sweep = 1'b1;
				if (st.sweep_last) state_d = pczb_pkg::ST_EMPTY;
			end
			pczb_pkg::ST_EMPTY: begin
				ctl.emit = pczb_pkg::EM_SPACE;
				state_d = pczb_pkg::ST_IDLE;
			end
			pczb_pkg::ST_M0: begin
				ctl.mul_en = 1'b1;
				ctl.mul_sel = pczb_pkg::MUL_XC;
				state_d = pczb_pkg::ST_M1;
			end
			pczb_pkg::ST_M1: begin
				ctl.mul_en = 1'b1;
				ctl.mul_sel = pczb_pkg::MUL_ZS;
				ctl.acc_en = 1'b1;
				ctl.acc_sel = pczb_pkg::ACC_RX_LD;
				state_d = pczb_pkg::ST_M2;
			end
			pczb_pkg::ST_M2: begin
				ctl.mul_en = 1'b1;
				ctl.mul_sel = pczb_pkg::MUL_ZC;
				ctl.acc_en = 1'b1;
				ctl.acc_sel = pczb_pkg::ACC_RX_SUB;
				state_d = pczb_pkg::ST_M3;
			end
			pczb_pkg::ST_M3: begin
				ctl.mul_en = 1'b1;
				ctl.mul_sel = pczb_pkg::MUL_XS;
				ctl.acc_en = 1'b1;
				ctl.acc_sel = pczb_pkg::ACC_RZ_LD;
				state_d = pczb_pkg::ST_M4;
			end
			pczb_pkg::ST_M4: begin
				ctl.acc_en = 1'b1;
				ctl.acc_sel = pczb_pkg::ACC_RZ_ADD;
				state_d = pczb_pkg::ST_TZ;
			end
			pczb_pkg::ST_TZ: begin
				ctl.tz_en = 1'b1;
				state_d = pczb_pkg::ST_MC;
			end
			pczb_pkg::ST_MC: begin
				if (st.drop_early) begin
					ctl.emit = pczb_pkg::EM_SPACE;
					state_d = pczb_pkg::ST_IDLE;
				end else begin
					ctl.mul_en = 1'b1;
					ctl.mul_sel = pczb_pkg::MUL_CNUM;
					state_d = pczb_pkg::ST_DC;
				end
			end
			pczb_pkg::ST_DC: begin
				ctl.div_load = 1'b1;
				ctl.mul_en = 1'b1;
				ctl.mul_sel = pczb_pkg::MUL_RNUM;
				state_d = pczb_pkg::ST_DCI;
			end
			pczb_pkg::ST_DCI: begin
				ctl.div_step = 1'b1;
				if (st.div_last) state_d = pczb_pkg::ST_DR;
			end
			pczb_pkg::ST_DR: begin
				ctl.div_load = 1'b1;
				ctl.div_row = 1'b1;
				state_d = pczb_pkg::ST_DRI;
			end
			pczb_pkg::ST_DRI: begin
				ctl.div_step = 1'b1;
				if (st.div_last) state_d = pczb_pkg::ST_CHK;
			end
			pczb_pkg::ST_CHK: begin
				ctl.mem_rd = 1'b1;
				state_d = pczb_pkg::ST_UPD;
			end
			pczb_pkg::ST_UPD: begin
				ctl.emit = pczb_pkg::EM_PLOT;
				state_d = pczb_pkg::ST_IDLE;
			end
			pczb_pkg::ST_RD: begin
				ctl.mem_rd = 1'b1;
				ctl.rd_pix = 1'b1;
				state_d = pczb_pkg::ST_RDO;
			end
			pczb_pkg::ST_RDO: begin
				ctl.emit = pczb_pkg::EM_READ;
				state_d = pczb_pkg::ST_IDLE;
			end
			default: state_d = pczb_pkg::ST_INIT;
		endcase
	end

	`CHK_PROP(a_busy_after_accept, clk, arst_n, (start && !busy) |=> busy)
	`CHK_PROP(a_emit_then_idle, clk, arst_n, (ctl.emit != pczb_pkg::EM_NONE) |=> !busy)
	`CHK_PROP(a_idle_only_after_result, clk, arst_n,
		$fell(busy) |-> ($past(ctl.emit != pczb_pkg::EM_NONE) || $past(state_q == pczb_pkg::ST_INIT)))

endmodule

@@ design/pczb_dpath.sv @@
// Datapath of the renderer: registers, shared multiplier, serial divider,
// depth store and result register. Depends on pczb_pkg.
module pczb_dpath #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pczb_pkg::item_t   item,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_addr,
	input  logic [19:0]       cfg_wdata,
	input  pczb_pkg::ctl_t    ctl,
	output pczb_pkg::status_t st,
	output pczb_pkg::result_t result,
	output logic              done
);

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int MW    = $clog2(CELLS);
	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int KW    = $clog2(pczb_pkg::NW);
	localparam int TZW   = pczb_pkg::TZW;
	localparam int NW    = pczb_pkg::NW;
	localparam int DW    = pczb_pkg::DW;
	localparam int PW    = pczb_pkg::PW;

	// configuration
	logic signed [17:0] cos_q, sin_q;
	logic [19:0]        off_q;
	logic [7:0]         cols_q;
	logic [6:0]         rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q  <= 18'sd65536;
			sin_q  <= 18'sd0;
			off_q  <= 20'd196608;
			cols_q <= 8'd100;
			rows_q <= 7'd39;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pczb_pkg::CFG_COS:  cos_q  <= cfg_wdata[17:0];
				pczb_pkg::CFG_SIN:  sin_q  <= cfg_wdata[17:0];
				pczb_pkg::CFG_OFF:  off_q  <= cfg_wdata;
				pczb_pkg::CFG_COLS: cols_q <= cfg_wdata[7:0];
				pczb_pkg::CFG_ROWS: rows_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] w;
	logic [RW-1:0] h;
	assign w = (32'(cols_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_q);
	assign h = (32'(rows_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_q);

	pczb_pkg::item_t in_q;
	always_ff @(posedge clk) begin
		if (ctl.load) in_q <= item;
	end

	// shared multiplier
	logic signed [pczb_pkg::AW-1:0] mul_a;
	logic signed [pczb_pkg::BW-1:0] mul_b;
	logic signed [PW-1:0]           prod_q, rxa_q, rza_q;
	logic signed [TZW-1:0]          tz_q;
	logic signed [pczb_pkg::AW-1:0] rx_q;

	always_comb begin
		mul_a = pczb_pkg::AW'(in_q.vertex_x);
		mul_b = cos_q;
		case (ctl.mul_sel)
			pczb_pkg::MUL_XC: begin
				mul_a = pczb_pkg::AW'(in_q.vertex_x);
				mul_b = cos_q;
			end
			pczb_pkg::MUL_ZS: begin
				mul_a = pczb_pkg::AW'(in_q.vertex_z);
				mul_b = sin_q;
			end
			pczb_pkg::MUL_ZC: begin
				mul_a = pczb_pkg::AW'(in_q.vertex_z);
				mul_b = cos_q;
			end
			pczb_pkg::MUL_XS: begin
				mul_a = pczb_pkg::AW'(in_q.vertex_x);
				mul_b = sin_q;
			end
			pczb_pkg::MUL_CNUM: begin
				mul_a = rx_q + pczb_pkg::AW'(tz_q);
				mul_b = pczb_pkg::BW'(w - CW'(1));
			end
			pczb_pkg::MUL_RNUM: begin
				mul_a = pczb_pkg::AW'(tz_q) - pczb_pkg::AW'(in_q.vertex_y);
				mul_b = pczb_pkg::BW'(h - RW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) prod_q <= mul_a * mul_b;
		if (ctl.acc_en) begin
			case (ctl.acc_sel)
				pczb_pkg::ACC_RX_LD:  rxa_q <= prod_q;
				pczb_pkg::ACC_RX_SUB: rxa_q <= rxa_q - prod_q;
				pczb_pkg::ACC_RZ_LD:  rza_q <= prod_q;
				default:              rza_q <= rza_q + prod_q;
			endcase
		end
		if (ctl.tz_en) begin
			// arithmetic shift floors the Q.16 products
			tz_q <= TZW'(rza_q >>> 16) + $signed({{(TZW - 20){1'b0}}, off_q});
			rx_q <= pczb_pkg::AW'(rxa_q >>> 16);
		end
	end

	assign st.drop_early = (tz_q <= TZW'(pczb_pkg::NEAR_LIMIT)) || (w == '0) || (h == '0);

	// restoring divider on magnitudes, one quotient bit per cycle
	logic [NW-1:0]  n_q, col_q;
	logic           neg_q, col_neg_q;
	logic [DW-1:0]  rem_q;
	logic [KW-1:0]  cnt_q;
	logic [DW-1:0]  den;
	logic [DW:0]    rem_sh;
	logic [PW-1:0]  prod_abs;

	assign den      = DW'(tz_q) << 1;
	assign rem_sh   = {rem_q, n_q[NW-1]};
	assign prod_abs = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
	assign st.div_last = (cnt_q == KW'(NW - 1));

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			if (ctl.div_row) begin
				col_q     <= n_q;
				col_neg_q <= neg_q;
			end
			n_q   <= NW'(prod_abs);
			neg_q <= prod_q[PW-1];
			rem_q <= '0;
			cnt_q <= '0;
		end else if (ctl.div_step) begin
			if (rem_sh >= {1'b0, den}) begin
				rem_q <= DW'(rem_sh - {1'b0, den});
				n_q   <= {n_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= DW'(rem_sh);
				n_q   <= {n_q[NW-2:0], 1'b0};
			end
			cnt_q <= cnt_q + KW'(1);
		end
	end

	// truncation toward zero: a negative quotient is only in range when it is zero
	logic          col_ok, row_ok, plot_ok, rd_ok, win;
	logic [CW-1:0] col;
	logic [RW-1:0] row;
	logic [MW-1:0] plot_cell, rd_cell, sweep_q, mem_ra, mem_wa;
	logic [23:0]   d;
	logic [24:0]   mem [0:CELLS-1];
	logic [24:0]   mem_q, mem_wd;
	logic          mem_we;

	assign col_ok  = (!col_neg_q || col_q == '0) && (col_q < NW'(w));
	assign row_ok  = (!neg_q || n_q == '0) && (n_q < NW'(h));
	assign plot_ok = col_ok && row_ok;
	assign col     = CW'(col_q);
	assign row     = RW'(n_q);
	assign plot_cell = plot_ok ? MW'(32'(row) * MAX_COLS + 32'(col)) : '0;
	assign rd_ok   = (32'(in_q.read_col) < 32'(w)) && (32'(in_q.read_row) < 32'(h));
	assign rd_cell = rd_ok ? MW'(32'(in_q.read_row) * MAX_COLS + 32'(in_q.read_col)) : '0;
	assign d       = (tz_q > TZW'(24'hFFFFFF)) ? 24'hFFFFFF : tz_q[23:0];
	assign win     = plot_ok && (!mem_q[24] || d < mem_q[23:0]);

	assign st.sweep_last = (sweep_q == MW'(CELLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sweep_q <= '0;
		else if (ctl.sweep) sweep_q <= st.sweep_last ? '0 : sweep_q + MW'(1);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = plot_cell;
		mem_wd = {1'b1, d};
		if (ctl.sweep) begin
			mem_we = 1'b1;
			mem_wa = sweep_q;
			mem_wd = '0;
		end else if (ctl.emit == pczb_pkg::EM_PLOT && win) begin
			mem_we = 1'b1;
		end
	end

	assign mem_ra = ctl.rd_pix ? rd_cell : plot_cell;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (ctl.mem_rd) mem_q <= mem[mem_ra];
	end

	// result register
	pczb_pkg::result_t res_d, res_q;
	logic              done_q;

	always_comb begin
		res_d = '0;
		res_d.glyph = pczb_pkg::SPACE;
		if (ctl.emit == pczb_pkg::EM_PLOT && plot_ok) begin
			res_d.screen_col = 7'(col);
			res_d.screen_row = 6'(row);
			if (win) begin
				res_d.plotted = 1'b1;
				res_d.glyph   = pczb_pkg::glyph_of(d);
			end
		end else if (ctl.emit == pczb_pkg::EM_READ && rd_ok && mem_q[24]) begin
			res_d.glyph = pczb_pkg::glyph_of(mem_q[23:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= (ctl.emit != pczb_pkg::EM_NONE);
	end

	always_ff @(posedge clk) begin
		if (ctl.emit != pczb_pkg::EM_NONE) res_q <= res_d;
	end

	assign result = res_q;
	assign done   = done_q;

endmodule

@@ design/point_cloud_zbuffer_render.sv @@
// Top level of the point cloud z-buffer renderer.
// Depends on pczb_pkg, pczb_ctrl and pczb_dpath.
//
//  channel   ports                          handshake
//  -------   -----------------------------  -------------------------------
//  command   item (item_t)                  taken when start && !busy
//  result    result (result_t)              valid for one cycle with done
//  config    cfg_we, cfg_addr, cfg_wdata    written when cfg_we
//
// A plot runs four rotation products through one shared
// multiplier, two numerator products, then two 40-step serial divisions
// (one quotient bit a cycle), a depth store read and the update.
// A clear sweeps the depth store one entry a cycle.
// After reset busy stays high while the store is swept.
// The result cannot be stalled; each one appears for exactly one cycle.
module point_cloud_zbuffer_render #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pczb_pkg::item_t   item,
	output logic              done,
	output pczb_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_addr,
	input  logic [19:0]       cfg_wdata
);

	// command and status between sequencer and datapath
	pczb_pkg::ctl_t    ctl;
	pczb_pkg::status_t st;

	pczb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (item.cmd),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	// hold the item, rotate, project, depth test and register the result
	pczb_dpath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.st        (st),
		.result    (result),
		.done      (done)
	);

endmodule

@@ tb/sv/point_cloud_zbuffer_render_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the point cloud z-buffer renderer: rotation, projection, depth test.
// Depends on pczb_pkg and point_cloud_zbuffer_render.
module point_cloud_zbuffer_render_tb;

	localparam int COLS_MAX = 128;
	localparam int ROWS_MAX = 64;
	localparam int CELL_COUNT = COLS_MAX * ROWS_MAX;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	pczb_pkg::item_t   item;
	logic              done;
	pczb_pkg::result_t result;
	logic              cfg_we;
	logic [2:0]        cfg_addr;
	logic [19:0]       cfg_wdata;

	point_cloud_zbuffer_render #(.MAX_COLS(COLS_MAX), .MAX_ROWS(ROWS_MAX)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// Mirror of the block's registers and depth store
	longint      m_cos, m_sin, m_offset;
	int unsigned m_cols, m_rows;
	logic [23:0] m_depth [CELL_COUNT];
	logic        m_mark  [CELL_COUNT];

	pczb_pkg::item_t   pending_items[$];
	pczb_pkg::result_t expected_results[$];
	int      idle_pct;
	int      issued_cnt, accepted_cnt;
	int      error_cnt;

	always #5 clk = ~clk;

	function automatic logic [7:0] depth_glyph(longint d);
		int idx;
		if (d <= 98304) idx = 8;
		else if (d >= 262144) idx = 0;
		else idx = int'(((262144 - d) * 8) / 163840);
		return pczb_pkg::RAMP[idx];
	endfunction

	// Work out the result of one item and advance the mirrored state
	function automatic pczb_pkg::result_t render_predict(pczb_pkg::item_t it);
		pczb_pkg::result_t r;
		longint      x, y, z, rx, rz, tz, col, row;
		int unsigned w, h, pix;
		logic [23:0] d;
		r = '{glyph: pczb_pkg::SPACE, plotted: 1'b0, screen_col: '0, screen_row: '0};
		w = (m_cols > COLS_MAX) ? COLS_MAX : m_cols;
		h = (m_rows > ROWS_MAX) ? ROWS_MAX : m_rows;
		if (it.cmd == pczb_pkg::CMD_CLEAR) begin
			foreach (m_mark[i]) m_mark[i] = 1'b0;
		end else if (it.cmd == pczb_pkg::CMD_PLOT) begin
			x = it.vertex_x;
			y = it.vertex_y;
			z = it.vertex_z;
			// arithmetic shift of a 64-bit value floors the Q.16 product
			rx = (x * m_cos - z * m_sin) >>> 16;
			rz = (z * m_cos + x * m_sin) >>> 16;
			tz = rz + m_offset;
			if (tz > pczb_pkg::NEAR_LIMIT && w > 0 && h > 0) begin
				col = ((rx + tz) * longint'(w - 1)) / (2 * tz);
				row = ((tz - y) * longint'(h - 1)) / (2 * tz);
				if (col >= 0 && col < w && row >= 0 && row < h) begin
					pix = int'(row) * COLS_MAX + int'(col);
					d = (tz > 64'hFFFFFF) ? 24'hFFFFFF : tz[23:0];
					r.screen_col = col[6:0];
					r.screen_row = row[5:0];
					if (!m_mark[pix] || d < m_depth[pix]) begin
						m_depth[pix] = d;
						m_mark[pix] = 1'b1;
						r.plotted = 1'b1;
						r.glyph = depth_glyph(d);
					end
				end
			end
		end else if (it.cmd == pczb_pkg::CMD_READ) begin
			if (it.read_col < w && it.read_row < h) begin
				pix = it.read_row * COLS_MAX + it.read_col;
				if (m_mark[pix]) r.glyph = depth_glyph(m_depth[pix]);
			end
		end
		return r;
	endfunction

	// Driver: hold start until the item is taken, then advance or idle
	always @(negedge clk) begin
		if (arst_n && (!start || accepted_cnt == issued_cnt)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
				item <= pending_items.pop_front();
				start <= 1'b1;
				issued_cnt <= issued_cnt + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check the result first, then predict the item taken at this edge
	always @(posedge clk) begin
		pczb_pkg::result_t want;
		if (done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected, actual %p", $time, result);
				error_cnt++;
			end else begin
				want = expected_results.pop_front();
				if (result.glyph !== want.glyph) begin
					$display("%0t: glyph expected %h actual %h", $time, want.glyph,
						result.glyph);
					error_cnt++;
				end
				if (result.plotted !== want.plotted) begin
					$display("%0t: plotted expected %b actual %b", $time, want.plotted,
						result.plotted);
					error_cnt++;
				end
				if (result.screen_col !== want.screen_col) begin
					$display("%0t: screen_col expected %0d actual %0d", $time,
						want.screen_col, result.screen_col);
					error_cnt++;
				end
				if (result.screen_row !== want.screen_row) begin
					$display("%0t: screen_row expected %0d actual %0d", $time,
						want.screen_row, result.screen_row);
					error_cnt++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			expected_results.push_back(render_predict(item));
			accepted_cnt <= accepted_cnt + 1;
		end
	end

	function automatic pczb_pkg::item_t make_item(logic [1:0] c, int x, int y, int z,
		int rc, int rr);
		pczb_pkg::item_t it;
		it.cmd = c;
		it.vertex_x = x[23:0];
		it.vertex_y = y[23:0];
		it.vertex_z = z[23:0];
		it.read_col = rc[6:0];
		it.read_row = rr[5:0];
		return it;
	endfunction

	// Coordinate near the unit cube, so most vertices land on the grid
	function automatic int near_coord();
		return int'($urandom_range(262144)) - 131072;
	endfunction

	function automatic pczb_pkg::item_t random_item();
		pczb_pkg::item_t it;
		int              pick;
		logic [95:0]     raw;
		pick = $urandom_range(99);
		it = make_item(pczb_pkg::CMD_PLOT, near_coord(), near_coord(), near_coord(),
			$urandom_range(127), $urandom_range(63));
		if (pick < 25) begin
			it.cmd = pczb_pkg::CMD_READ;
		end else if (pick < 27) begin
			it.cmd = pczb_pkg::CMD_NOP;
		end else if (pick < 37) begin
			// noise: every bit of every field
			raw = {$urandom, $urandom, $urandom};
			it = raw[$bits(pczb_pkg::item_t)-1:0];
			if (it.cmd == pczb_pkg::CMD_CLEAR) it.cmd = pczb_pkg::CMD_PLOT;
		end
		return it;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [19:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			pczb_pkg::CFG_COS:  m_cos = longint'(signed'(val[17:0]));
			pczb_pkg::CFG_SIN:  m_sin = longint'(signed'(val[17:0]));
			pczb_pkg::CFG_OFF:  m_offset = val;
			pczb_pkg::CFG_COLS: m_cols = val[7:0];
			pczb_pkg::CFG_ROWS: m_rows = val[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(int c, int s, int off, int cols, int rows);
		write_reg(pczb_pkg::CFG_COS, c[19:0]);
		write_reg(pczb_pkg::CFG_SIN, s[19:0]);
		write_reg(pczb_pkg::CFG_OFF, off[19:0]);
		write_reg(pczb_pkg::CFG_COLS, cols[19:0]);
		write_reg(pczb_pkg::CFG_ROWS, rows[19:0]);
	endtask

	// Pause the sender until every expected result has come and the block is idle
	task automatic drain();
		wait (pending_items.size() == 0 && !start && expected_results.size() == 0);
		repeat (8) @(negedge clk);
		wait (!busy);
		@(negedge clk);
	endtask

	task automatic random_phase(int count, int pct);
		idle_pct = pct;
		pending_items.push_back(make_item(pczb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
		repeat (count) pending_items.push_back(random_item());
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		issued_cnt = 0;
		accepted_cnt = 0;
		error_cnt = 0;
		idle_pct = 0;
		m_cos = 65536;
		m_sin = 0;
		m_offset = 196608;
		m_cols = 100;
		m_rows = 39;
		foreach (m_mark[i]) begin
			m_mark[i] = 1'b0;
			m_depth[i] = '0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		wait (!busy);
		@(negedge clk);

		// Directed items at reset settings
		pending_items.push_back(make_item(pczb_pkg::CMD_READ, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_READ, 0, 0, 0, 127, 63));
		pending_items.push_back(make_item(pczb_pkg::CMD_PLOT, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_PLOT, 0, 0, 65536, 0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_PLOT, 0, 0, -65536, 0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_READ, 0, 0, 0, 49, 19));
		pending_items.push_back(make_item(pczb_pkg::CMD_PLOT, 0, 0, -131072, 0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_PLOT, 0, 0, -196608, 0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_PLOT, 0, 0, -196543, 0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_PLOT, 8388607, 8388607, 8388607,
			0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_PLOT, -8388608, -8388608,
			-8388608, 0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_PLOT, 190000, -190000, 0, 0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_PLOT, -196608, 196608, 0, 0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_NOP, -1, -1, -1, 127, 63));
		pending_items.push_back(make_item(pczb_pkg::CMD_READ, 0, 0, 0, 49, 19));
		pending_items.push_back(make_item(pczb_pkg::CMD_READ, -1, -1, -1, 100, 39));
		pending_items.push_back(make_item(pczb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(pczb_pkg::CMD_READ, 0, 0, 0, 49, 19));
		pending_items.push_back(make_item(pczb_pkg::CMD_PLOT, 0, 0, 0, 0, 0));
		drain();

		// Random phases over a range of settings, extremes among them
		random_phase(90, 0);
		configure(-65536, 0, 196608, 128, 64);
		random_phase(90, 81);
		configure(0, 65536, 98304, 20, 10);
		random_phase(90, 30);
		configure(46341, -46341, 262144, 255, 127);
		random_phase(90, 0);
		configure(131071, -131072, 0, 64, 32);
		random_phase(70, 81);
		configure(-46341, 46341, 1048575, 128, 64);
		random_phase(70, 30);
		configure(0, 0, 196608, 0, 0);
		random_phase(40, 0);
		configure($urandom_range(131072) - 65536, $urandom_range(131072) - 65536,
			$urandom_range(327680), $urandom_range(20, 128), $urandom_range(10, 64));
		random_phase(90, 81);
		configure(65536, 0, 196608, 100, 39);
		random_phase(90, 30);

		repeat (200) @(negedge clk);
		if (error_cnt == 0 && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
